[rtl/bbf_pkg.sv]
`default_nettype none
package bbf_pkg;

  localparam int TOTAL_W    = 25;
  localparam int STATUS_W   = 3;
  localparam int EVICT_W    = 6;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [TOTAL_W-1:0] CAP_RESET = 25'd1048576;

  // action codes
  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_EVICT    = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED    = 3'd0,
    ST_EVICTED     = 3'd1,
    ST_REJECTED    = 3'd2,
    ST_DRAINED     = 3'd3,
    ST_DRAIN_EMPTY = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_EV_CHK,
    S_EV_RD,
    S_EV_ACC,
    S_EV_FIX,
    S_APPEND,
    S_EMIT,
    S_DR_RD,
    S_DR_OUT
  } state_e;

  typedef struct packed {
    logic    latch;
    logic    set_status;
    status_e status;
    logic    evict_step;
    logic    evict_fix;
    logic    append;
    logic    emit;
    logic    drain_emit;
  } cmd_t;

  typedef struct packed {
    logic in_drain;
    logic fits;
    logic evict_en;
    logic ev_more;
    logic queue_empty;
    logic last_entry;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

[rtl/bbf_in_if.sv]
`default_nettype none
interface bbf_in_if #(
  parameter int SIZE_BITS   = 16,
  parameter int HANDLE_BITS = 32
) ();
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [HANDLE_BITS-1:0] entry_handle;
  logic [SIZE_BITS-1:0]   entry_bytes;

  modport source (output valid, action, entry_handle, entry_bytes, input ready);
  modport sink   (input valid, action, entry_handle, entry_bytes, output ready);
endinterface
`default_nettype wire

[rtl/bbf_out_if.sv]
`default_nettype none
interface bbf_out_if #(
  parameter int SIZE_BITS   = 16,
  parameter int HANDLE_BITS = 32
) ();
  logic                          valid;
  logic                          ready;
  logic [bbf_pkg::STATUS_W-1:0]  status;
  logic [HANDLE_BITS-1:0]        out_handle;
  logic [SIZE_BITS-1:0]          out_bytes;
  logic                          last;
  logic [bbf_pkg::EVICT_W-1:0]   evicted_count;
  logic [bbf_pkg::TOTAL_W-1:0]   total_bytes;
  logic                          is_empty;
  logic                          is_full;

  modport source (
    output valid, status, out_handle, out_bytes, last, evicted_count, total_bytes,
           is_empty, is_full,
    input  ready
  );
  modport sink (
    input  valid, status, out_handle, out_bytes, last, evicted_count, total_bytes,
           is_empty, is_full,
    output ready
  );
endinterface
`default_nettype wire

[rtl/bbf_ctrl.sv]
`default_nettype none
module bbf_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire bbf_pkg::sts_t sts_i,
  output bbf_pkg::cmd_t      cmd_o
);

  bbf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bbf_pkg::S_IDLE: begin
        if (in_valid_i) state_d = bbf_pkg::S_DECIDE;
      end
      bbf_pkg::S_DECIDE: begin
        if (sts_i.in_drain) begin
          state_d = sts_i.queue_empty ? bbf_pkg::S_EMIT : bbf_pkg::S_DR_RD;
        end else if (sts_i.fits || !sts_i.evict_en) begin
          state_d = bbf_pkg::S_EMIT;
        end else begin
          state_d = bbf_pkg::S_EV_CHK;
        end
      end
      bbf_pkg::S_EV_CHK: state_d = sts_i.ev_more ? bbf_pkg::S_EV_RD : bbf_pkg::S_EV_FIX;
      bbf_pkg::S_EV_RD:  state_d = bbf_pkg::S_EV_ACC;
      bbf_pkg::S_EV_ACC: state_d = bbf_pkg::S_EV_CHK;
      bbf_pkg::S_EV_FIX: state_d = bbf_pkg::S_APPEND;
      bbf_pkg::S_APPEND: state_d = bbf_pkg::S_EMIT;
      bbf_pkg::S_EMIT: begin
        if (sts_i.out_free) state_d = bbf_pkg::S_IDLE;
      end
      bbf_pkg::S_DR_RD:  state_d = bbf_pkg::S_DR_OUT;
      bbf_pkg::S_DR_OUT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.last_entry ? bbf_pkg::S_IDLE : bbf_pkg::S_DR_RD;
        end
      end
      default: state_d = bbf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.status = bbf_pkg::ST_ACCEPTED;
    in_ready_o   = 1'b0;
    unique case (state_q)
      bbf_pkg::S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      bbf_pkg::S_DECIDE: begin
        cmd_o.set_status = 1'b1;
        if (sts_i.in_drain) begin
          cmd_o.status = bbf_pkg::ST_DRAIN_EMPTY;
        end else if (sts_i.fits) begin
          cmd_o.status = bbf_pkg::ST_ACCEPTED;
          cmd_o.append = 1'b1;
        end else if (sts_i.evict_en) begin
          cmd_o.status = bbf_pkg::ST_EVICTED;
        end else begin
          cmd_o.status = bbf_pkg::ST_REJECTED;
        end
      end
      bbf_pkg::S_EV_CHK: ;
      bbf_pkg::S_EV_RD:  ;
      bbf_pkg::S_EV_ACC: cmd_o.evict_step = 1'b1;
      bbf_pkg::S_EV_FIX: cmd_o.evict_fix = 1'b1;
      bbf_pkg::S_APPEND: cmd_o.append = 1'b1;
      bbf_pkg::S_EMIT:   cmd_o.emit = sts_i.out_free;
      bbf_pkg::S_DR_RD:  ;
      bbf_pkg::S_DR_OUT: cmd_o.drain_emit = sts_i.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[rtl/bbf_dp.sv]
`default_nettype none
module bbf_dp #(
  parameter int DEPTH       = 32,
  parameter int SIZE_BITS   = 16,
  parameter int HANDLE_BITS = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bbf_pkg::cmd_t                cmd_i,
  output bbf_pkg::sts_t                     sts_o,
  input  wire logic [bbf_pkg::TOTAL_W-1:0]  capacity_i,
  input  wire logic                         evict_i,
  input  wire logic                         action_i,
  input  wire logic [HANDLE_BITS-1:0]       handle_i,
  input  wire logic [SIZE_BITS-1:0]         bytes_i,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output logic [bbf_pkg::STATUS_W-1:0]      status_o,
  output logic [HANDLE_BITS-1:0]            out_handle_o,
  output logic [SIZE_BITS-1:0]              out_bytes_o,
  output logic                              last_o,
  output logic [bbf_pkg::EVICT_W-1:0]       evicted_o,
  output logic [bbf_pkg::TOTAL_W-1:0]       total_o,
  output logic                              empty_o,
  output logic                              full_o
);

  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int TW      = bbf_pkg::TOTAL_W;
  localparam int FREED_W = SIZE_BITS + CNT_W;
  localparam int WIDE_W  = (FREED_W > TW) ? FREED_W : TW;
  localparam int SUM_W   = TW + 1;

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  logic [HANDLE_BITS-1:0] hmem [DEPTH];
  logic [SIZE_BITS-1:0]   smem [DEPTH];
  logic [HANDLE_BITS-1:0] rd_handle_q;
  logic [SIZE_BITS-1:0]   rd_bytes_q;

  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [TW-1:0]    total_q, total_d;

  logic                   action_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [SIZE_BITS-1:0]   bytes_q;
  logic [FREED_W-1:0]     freed_q;
  logic [CNT_W-1:0]       dropped_q;
  bbf_pkg::status_e       status_q;

  logic                   out_valid_q;
  bbf_pkg::status_e       out_status_q;
  logic [HANDLE_BITS-1:0] out_handle_q;
  logic [SIZE_BITS-1:0]   out_bytes_q;
  logic                   out_last_q;
  logic [bbf_pkg::EVICT_W-1:0] out_evicted_q;
  logic [TW-1:0]          out_total_q;
  logic                   out_empty_q;
  logic                   out_full_q;

  logic [SUM_W-1:0]  sum;
  logic [TW-1:0]     total_sat;
  logic [WIDE_W-1:0] freed_wide, total_wide;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  // descriptor store, read port fixed at the head
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      hmem[tail_q] <= handle_q;
      smem[tail_q] <= bytes_q;
    end
    rd_handle_q <= hmem[head_q];
    rd_bytes_q  <= smem[head_q];
  end

  assign sum        = {1'b0, total_q} + SUM_W'(bytes_q);
  assign total_sat  = sum[TW] ? '1 : sum[TW-1:0];
  assign freed_wide = WIDE_W'(freed_q);
  assign total_wide = WIDE_W'(total_q);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    total_d = total_q;
    if (cmd_i.evict_step) begin
      head_d  = next_slot(head_q);
      count_d = count_q - 1'b1;
    end
    if (cmd_i.evict_fix) begin
      if (freed_wide <= total_wide) begin
        total_d = TW'(total_wide - freed_wide);
      end else begin
        // freed more than the saturated total holds: start over
        head_d  = '0;
        tail_d  = '0;
        count_d = '0;
        total_d = '0;
      end
    end
    if (cmd_i.append) begin
      tail_d  = next_slot(tail_q);
      count_d = count_q + 1'b1;
      total_d = total_sat;
    end
    if (cmd_i.drain_emit) begin
      if (count_q == CNT_W'(1)) begin
        head_d  = '0;
        tail_d  = '0;
        count_d = '0;
        total_d = '0;
      end else begin
        head_d  = next_slot(head_q);
        count_d = count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      total_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      action_q  <= action_i;
      handle_q  <= handle_i;
      bytes_q   <= bytes_i;
      freed_q   <= '0;
      dropped_q <= '0;
    end else if (cmd_i.evict_step) begin
      freed_q   <= freed_q + FREED_W'(rd_bytes_q);
      dropped_q <= dropped_q + 1'b1;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.drain_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // drained entries report the queue as it stands after the drain
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q  <= status_q;
      out_handle_q  <= '0;
      out_bytes_q   <= '0;
      out_last_q    <= 1'b1;
      out_evicted_q <= bbf_pkg::EVICT_W'(dropped_q);
      out_total_q   <= total_q;
      out_empty_q   <= (count_q == '0);
      out_full_q    <= (total_q >= capacity_i);
    end else if (cmd_i.drain_emit) begin
      out_status_q  <= bbf_pkg::ST_DRAINED;
      out_handle_q  <= rd_handle_q;
      out_bytes_q   <= rd_bytes_q;
      out_last_q    <= (count_q == CNT_W'(1));
      out_evicted_q <= '0;
      out_total_q   <= '0;
      out_empty_q   <= 1'b1;
      out_full_q    <= (capacity_i == '0);
    end
  end

  assign sts_o.in_drain    = (action_q == bbf_pkg::ACT_DRAIN);
  assign sts_o.fits        = (count_q != FULL_CNT) && (total_q < capacity_i);
  assign sts_o.evict_en    = evict_i;
  assign sts_o.ev_more     = (count_q != '0) &&
                             ((freed_q < FREED_W'(bytes_q)) || (count_q == FULL_CNT));
  assign sts_o.queue_empty = (count_q == '0);
  assign sts_o.last_entry  = (count_q == CNT_W'(1));
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign out_handle_o = out_handle_q;
  assign out_bytes_o  = out_bytes_q;
  assign last_o       = out_last_q;
  assign evicted_o    = out_evicted_q;
  assign total_o      = out_total_q;
  assign empty_o      = out_empty_q;
  assign full_o       = out_full_q;

endmodule
`default_nettype wire

[rtl/byte_budget_fifo_head_drop.sv]
// Sequential: input is ready only when idle. Plain push or reject: decide, then output.
// Evicting push: decide, then check, head read and accumulate per dropped entry, then
// fix-up, append, output; each head read goes through the one registered store read port.
// Drain: decide, then head read and output per entry, or just output if empty; stalls wait.
// Reset (rst_ni low, asynchronous): pointers, entry count, byte total and output valid clear;
// capacity returns to 1048576 and the evict policy to off. The store itself is not cleared.
`default_nettype none
module byte_budget_fifo_head_drop #(
  parameter int DEPTH       = 32,
  parameter int SIZE_BITS   = 16,
  parameter int HANDLE_BITS = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bbf_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [bbf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bbf_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready,
  bbf_in_if.sink                                 in_i,
  bbf_out_if.source                              out_o
);

  logic [bbf_pkg::TOTAL_W-1:0] cap_q;
  logic                        evict_q;
  logic                        reg_sel;
  bbf_pkg::cmd_t               cmd;
  bbf_pkg::sts_t               sts;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= bbf_pkg::CAP_RESET;
      evict_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        bbf_pkg::REG_CAPACITY: cap_q   <= pwdata[bbf_pkg::TOTAL_W-1:0];
        bbf_pkg::REG_EVICT:    evict_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      bbf_pkg::REG_CAPACITY: prdata = bbf_pkg::APB_DATA_W'(cap_q);
      bbf_pkg::REG_EVICT:    prdata = bbf_pkg::APB_DATA_W'(evict_q);
      default:               prdata = '0;
    endcase
  end

  bbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bbf_dp #(
    .DEPTH       (DEPTH),
    .SIZE_BITS   (SIZE_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .capacity_i   (cap_q),
    .evict_i      (evict_q),
    .action_i     (in_i.action),
    .handle_i     (in_i.entry_handle),
    .bytes_i      (in_i.entry_bytes),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .status_o     (out_o.status),
    .out_handle_o (out_o.out_handle),
    .out_bytes_o  (out_o.out_bytes),
    .last_o       (out_o.last),
    .evicted_o    (out_o.evicted_count),
    .total_o      (out_o.total_bytes),
    .empty_o      (out_o.is_empty),
    .full_o       (out_o.is_full)
  );

endmodule
`default_nettype wire

[tb/tb.sv]
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 32;
  localparam int SIZE_W      = 16;
  localparam int HANDLE_W    = 32;
  localparam int unsigned TOTAL_MAX = 33554431;
  localparam int HOLD_DELAY  = 20;
  localparam int HOLD_LEN    = 80;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int CMD_CAP     = 256;
  localparam int OWED_CAP    = 1024;

  typedef struct {
    logic                action;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   bytes;
    int                  gap;
  } fifo_cmd_t;

  typedef struct {
    bbf_pkg::status_e             status;
    logic [HANDLE_W-1:0]          handle;
    logic [SIZE_W-1:0]            bytes;
    logic                         last;
    logic [bbf_pkg::EVICT_W-1:0]  evicted;
    logic [bbf_pkg::TOTAL_W-1:0]  total;
    logic                         is_empty;
    logic                         is_full;
  } fifo_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [bbf_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [bbf_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [bbf_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  logic                  drv_valid = 1'b0;
  logic                  drv_action = 1'b0;
  logic [HANDLE_W-1:0]   drv_handle = '0;
  logic [SIZE_W-1:0]     drv_bytes = '0;
  logic                  rx_ready = 1'b0;

  logic                  hold_arm = 1'b0;
  logic                  hold_off = 1'b0;
  logic                  hold_done = 1'b0;
  int                    hold_cnt = 0;
  int                    quiet_cycles = 0;

  // shadow copy of the queue and its registers
  logic [HANDLE_W-1:0]   sh_handle [DEPTH];
  logic [SIZE_W-1:0]     sh_size [DEPTH];
  int                    sh_head = 0;
  int                    sh_tail = 0;
  int                    sh_count = 0;
  int unsigned           sh_total = 0;
  int unsigned           sh_cap = bbf_pkg::CAP_RESET;
  logic                  sh_evict = 1'b0;

  fifo_cmd_t             cmd_buf [CMD_CAP];
  int                    cmd_wr = 0;
  int                    cmd_rd = 0;
  fifo_result_t          owed_buf [OWED_CAP];
  int                    owed_wr = 0;
  int                    owed_rd = 0;
  fifo_cmd_t             drv_next;
  int                    tx_max = 0;
  int                    rx_max = 0;
  int                    tx_wait = 0;
  int                    rx_wait = 0;
  int                    sent_total = 0;
  int                    taken_total = 0;
  int                    results_seen = 0;
  int                    err_cnt = 0;
  int                    n_evict = 0;
  int                    n_reject = 0;
  int                    n_drained = 0;

  bbf_in_if  #(.SIZE_BITS(SIZE_W), .HANDLE_BITS(HANDLE_W)) in_if ();
  bbf_out_if #(.SIZE_BITS(SIZE_W), .HANDLE_BITS(HANDLE_W)) out_if ();

  assign in_if.valid        = drv_valid;
  assign in_if.action       = drv_action;
  assign in_if.entry_handle = drv_handle;
  assign in_if.entry_bytes  = drv_bytes;
  assign out_if.ready       = rx_ready;

  byte_budget_fifo_head_drop #(
    .DEPTH(DEPTH),
    .SIZE_BITS(SIZE_W),
    .HANDLE_BITS(HANDLE_W)
  ) u_top (
    .clk_i(clk),
    .rst_ni(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_i(in_if),
    .out_o(out_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void owe_result(bbf_pkg::status_e st, logic [HANDLE_W-1:0] h,
                                     logic [SIZE_W-1:0] b, logic lst, int dropped);
    fifo_result_t r;
    r.status   = st;
    r.handle   = h;
    r.bytes    = b;
    r.last     = lst;
    r.evicted  = dropped[bbf_pkg::EVICT_W-1:0];
    r.total    = sh_total[bbf_pkg::TOTAL_W-1:0];
    r.is_empty = (sh_count == 0);
    r.is_full  = (sh_total >= sh_cap);
    owed_buf[owed_wr % OWED_CAP] = r;
    owed_wr++;
  endfunction

  function automatic void append_entry(logic [HANDLE_W-1:0] h, logic [SIZE_W-1:0] b);
    int unsigned sum;
    sh_handle[sh_tail] = h;
    sh_size[sh_tail]   = b;
    sh_tail  = (sh_tail + 1) % DEPTH;
    sh_count++;
    sum      = sh_total + b;
    sh_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum;
  endfunction

  function automatic void advance_shadow_fifo(logic act, logic [HANDLE_W-1:0] h,
                                              logic [SIZE_W-1:0] b);
    int unsigned freed;
    int          dropped;
    int          n;
    int          idx;
    freed   = 0;
    dropped = 0;
    if (act == bbf_pkg::ACT_PUSH) begin
      if (sh_count < DEPTH && sh_total < sh_cap) begin
        append_entry(h, b);
        owe_result(bbf_pkg::ST_ACCEPTED, '0, '0, 1'b1, 0);
      end else if (sh_evict) begin
        // drop from the head until the new bytes are covered and a slot is free
        while (sh_count > 0 && (freed < b || sh_count >= DEPTH)) begin
          freed   += sh_size[sh_head];
          sh_head  = (sh_head + 1) % DEPTH;
          sh_count--;
          dropped++;
        end
        if (freed <= sh_total) begin
          sh_total -= freed;
        end else begin
          sh_head  = 0;
          sh_tail  = 0;
          sh_count = 0;
          sh_total = 0;
        end
        append_entry(h, b);
        owe_result(bbf_pkg::ST_EVICTED, '0, '0, 1'b1, dropped);
        n_evict++;
      end else begin
        owe_result(bbf_pkg::ST_REJECTED, '0, '0, 1'b1, 0);
        n_reject++;
      end
    end else if (sh_count == 0) begin
      owe_result(bbf_pkg::ST_DRAIN_EMPTY, '0, '0, 1'b1, 0);
    end else begin
      n        = sh_count;
      idx      = sh_head;
      sh_head  = 0;
      sh_tail  = 0;
      sh_count = 0;
      sh_total = 0;
      for (int k = 0; k < n; k++) begin
        owe_result(bbf_pkg::ST_DRAINED, sh_handle[idx], sh_size[idx], k == n - 1, 0);
        idx = (idx + 1) % DEPTH;
      end
      n_drained += n;
    end
  endfunction

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    err_cnt++;
    $display("%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  task automatic check_result();
    fifo_result_t w;
    if (owed_wr == owed_rd) begin
      flag_mismatch("result with nothing owed, status", out_if.status, 0);
      return;
    end
    w = owed_buf[owed_rd % OWED_CAP];
    owed_rd++;
    if (out_if.status !== w.status)
      flag_mismatch("status", out_if.status, w.status);
    if (out_if.out_handle !== w.handle)
      flag_mismatch("out_handle", out_if.out_handle, w.handle);
    if (out_if.out_bytes !== w.bytes)
      flag_mismatch("out_bytes", out_if.out_bytes, w.bytes);
    if (out_if.last !== w.last)
      flag_mismatch("last", out_if.last, w.last);
    if (out_if.evicted_count !== w.evicted)
      flag_mismatch("evicted_count", out_if.evicted_count, w.evicted);
    if (out_if.total_bytes !== w.total)
      flag_mismatch("total_bytes", out_if.total_bytes, w.total);
    if (out_if.is_empty !== w.is_empty)
      flag_mismatch("is_empty", out_if.is_empty, w.is_empty);
    if (out_if.is_full !== w.is_full)
      flag_mismatch("is_full", out_if.is_full, w.is_full);
  endtask

  function automatic void add_cmd(logic act, logic [HANDLE_W-1:0] h, logic [SIZE_W-1:0] b);
    fifo_cmd_t c;
    c.action = act;
    c.handle = h;
    c.bytes  = b;
    c.gap    = $urandom_range(tx_max, 0);
    cmd_buf[cmd_wr % CMD_CAP] = c;
    cmd_wr++;
    sent_total++;
  endfunction

  function automatic void add_random(int n, int drain_one_in, int bytes_hi);
    logic [SIZE_W-1:0] b;
    for (int i = 0; i < n; i++) begin
      b = ($urandom_range(9, 0) == 0) ? '0 : SIZE_W'($urandom_range(bytes_hi, 1));
      if (drain_one_in != 0 && $urandom_range(drain_one_in - 1, 0) == 0)
        add_cmd(bbf_pkg::ACT_DRAIN, $urandom, b);
      else
        add_cmd(bbf_pkg::ACT_PUSH, $urandom, b);
    end
  endfunction

  task automatic write_reg(logic idx, logic [bbf_pkg::APB_DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == bbf_pkg::REG_CAPACITY) sh_cap = val[bbf_pkg::TOTAL_W-1:0];
    else sh_evict = val[0];
  endtask

  task automatic wait_idle();
    while (taken_total != sent_total || owed_wr != owed_rd) @(posedge clk);
  endtask

  // driver: hold the item until transfer, then wait its gap before the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (drv_valid && in_if.ready) begin
        advance_shadow_fifo(drv_action, drv_handle, drv_bytes);
        taken_total++;
      end
      if (!drv_valid || in_if.ready) begin
        if (cmd_wr != cmd_rd && tx_wait >= cmd_buf[cmd_rd % CMD_CAP].gap) begin
          drv_next    = cmd_buf[cmd_rd % CMD_CAP];
          cmd_rd++;
          drv_valid  <= 1'b1;
          drv_action <= drv_next.action;
          drv_handle <= drv_next.handle;
          drv_bytes  <= drv_next.bytes;
          tx_wait = 0;
        end else begin
          drv_valid <= 1'b0;
          if (cmd_wr != cmd_rd) tx_wait++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_if.valid && rx_ready) begin
        check_result();
        results_seen++;
        rx_wait = $urandom_range(rx_max, 0);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      rx_ready <= !hold_off && rx_wait == 0;
    end
  end

  // one long receiver stall so the block backs up and stops taking input
  always @(posedge clk) begin
    if (hold_arm && !hold_done) begin
      hold_cnt  <= hold_cnt + 1;
      hold_off  <= hold_cnt >= HOLD_DELAY && hold_cnt < HOLD_DELAY + HOLD_LEN - 1;
      hold_done <= hold_cnt == HOLD_DELAY + HOLD_LEN;
    end
  end

  always @(posedge clk) begin
    if ((drv_valid && in_if.ready) || (out_if.valid && rx_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("no transfer for %0d cycles, stopping", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty drain, field extremes, zero-size push
    tx_max = 2;
    rx_max = 2;
    add_cmd(bbf_pkg::ACT_DRAIN, '0, '0);
    add_cmd(bbf_pkg::ACT_PUSH, '0, '0);
    add_cmd(bbf_pkg::ACT_PUSH, '1, '1);
    add_cmd(bbf_pkg::ACT_PUSH, 32'hA5A5_5A5A, 16'd1);
    add_cmd(bbf_pkg::ACT_DRAIN, '1, '1);
    wait_idle();

    // smallest budget, reject policy: first push overshoots, next is rejected
    write_reg(bbf_pkg::REG_CAPACITY, 32'd1);
    write_reg(bbf_pkg::REG_EVICT, 32'd0);
    add_cmd(bbf_pkg::ACT_PUSH, 32'h0000_1111, 16'd10);
    add_cmd(bbf_pkg::ACT_PUSH, 32'h0000_2222, 16'd3);
    wait_idle();

    // head drop: normal drop, nothing to drop for a zero-size push, drop to empty
    write_reg(bbf_pkg::REG_EVICT, 32'd1);
    add_cmd(bbf_pkg::ACT_PUSH, 32'h0000_3333, 16'd5);
    add_cmd(bbf_pkg::ACT_PUSH, 32'h0000_4444, 16'd0);
    add_cmd(bbf_pkg::ACT_PUSH, 32'h0000_5555, 16'hFFFF);
    add_cmd(bbf_pkg::ACT_DRAIN, '0, '0);
    wait_idle();

    // zero budget: every push goes over capacity
    write_reg(bbf_pkg::REG_CAPACITY, 32'd0);
    add_cmd(bbf_pkg::ACT_PUSH, 32'h8000_0001, 16'd0);
    add_cmd(bbf_pkg::ACT_PUSH, 32'h8000_0002, 16'd7);
    add_cmd(bbf_pkg::ACT_DRAIN, '0, '0);
    wait_idle();
    write_reg(bbf_pkg::REG_EVICT, 32'd0);
    add_cmd(bbf_pkg::ACT_PUSH, 32'h8000_0003, 16'd9);
    add_cmd(bbf_pkg::ACT_DRAIN, '0, '0);
    wait_idle();

    // largest nominal budget, reject policy: fill every slot
    tx_max = 6;
    rx_max = 6;
    write_reg(bbf_pkg::REG_CAPACITY, 32'd16777216);
    add_random(35, 0, 65535);
    add_cmd(bbf_pkg::ACT_DRAIN, $urandom, SIZE_W'($urandom));
    wait_idle();

    // full-width budget, head drop: slot pressure alone forces eviction
    tx_max = 0;
    rx_max = 0;
    write_reg(bbf_pkg::REG_CAPACITY, 32'h01FF_FFFF);
    write_reg(bbf_pkg::REG_EVICT, 32'd1);
    hold_arm <= 1'b1;
    add_random(35, 0, 64);
    add_cmd(bbf_pkg::ACT_DRAIN, $urandom, SIZE_W'($urandom));
    wait_idle();

    // tight random budget with head drop
    tx_max = 6;
    rx_max = 0;
    write_reg(bbf_pkg::REG_CAPACITY, $urandom_range(300000, 1000));
    add_random(20, 8, 65535);
    wait_idle();

    // tight random budget with rejects
    tx_max = 0;
    rx_max = 6;
    write_reg(bbf_pkg::REG_CAPACITY, $urandom_range(70000, 1));
    write_reg(bbf_pkg::REG_EVICT, 32'd0);
    add_random(15, 6, 65535);
    add_cmd(bbf_pkg::ACT_DRAIN, $urandom, SIZE_W'($urandom));
    wait_idle();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d items in, %0d results checked, %0d entries drained",
             taken_total, results_seen, n_drained);
    $display("%0d pushes took the eviction path, %0d pushes were rejected",
             n_evict, n_reject);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
